/* rtl/ttf_pkg.sv */
package ttf_pkg;

   localparam int COORD_W   = 32;                 // input coordinate width
   localparam int DIFF_W    = COORD_W + 1;        // edge vector component
   localparam int PROD_W    = 2 * DIFF_W;         // one product
   localparam int ACC_W     = PROD_W + 2;         // cross term / determinant
   localparam int MAG_W     = 30;                 // block-scaled magnitude
   localparam int SQ_W      = 2 * MAG_W + 2;      // sum of three squares
   localparam int ROOT_W    = SQ_W / 2;           // vector length
   localparam int REM_W     = ROOT_W + 3;         // root remainder
   localparam int ONE_SHIFT = 14;                 // Q2.14 unity
   localparam int QUO_W     = ONE_SHIFT + 1;      // quotient, at most one
   localparam int NUM_W     = MAG_W + QUO_W;      // dividend
   localparam int DREM_W    = ROOT_W + 2;         // divider remainder
   localparam int OUT_W     = 16;                 // Q2.14 component
   localparam int THR_W     = 16;
   localparam logic [THR_W-1:0] DET_THRESHOLD_RESET = 16'd7;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic signed [DIFF_W-1:0] p_x;
      logic signed [DIFF_W-1:0] p_y;
      logic signed [DIFF_W-1:0] p_z;
      logic signed [DIFF_W-1:0] q_x;
      logic signed [DIFF_W-1:0] q_y;
      logic signed [DIFF_W-1:0] q_z;
      logic signed [DIFF_W-1:0] s1;
      logic signed [DIFF_W-1:0] t1;
      logic signed [DIFF_W-1:0] s2;
      logic signed [DIFF_W-1:0] t2;
   } face_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] normal_x;
      logic signed [OUT_W-1:0] normal_y;
      logic signed [OUT_W-1:0] normal_z;
      logic signed [OUT_W-1:0] tangent_x;
      logic signed [OUT_W-1:0] tangent_y;
      logic signed [OUT_W-1:0] tangent_z;
      logic signed [OUT_W-1:0] bitangent_x;
      logic signed [OUT_W-1:0] bitangent_y;
      logic signed [OUT_W-1:0] bitangent_z;
   } frame_type;

endpackage

/* rtl/ttf_front.sv */
module ttf_front import ttf_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic signed [COORD_W-1:0] req_tex_u,
   input  logic signed [COORD_W-1:0] req_tex_v,
   input  logic                      req_start_mesh,
   output logic                      face_valid,
   input  logic                      face_ready,
   output face_type                  face
);

   logic [1:0] slot_ff, slot_in, slot_eff;
   logic signed [COORD_W-1:0] h0_x_ff, h0_y_ff, h0_z_ff, h0_u_ff, h0_v_ff;
   logic signed [COORD_W-1:0] h1_x_ff, h1_y_ff, h1_z_ff, h1_u_ff, h1_v_ff;
   logic accept;

   assign req_ready = face_ready;
   assign accept    = req_valid && req_ready;
   assign slot_eff  = req_start_mesh ? 2'd0 : slot_ff;
   assign face_valid = accept && (slot_eff == 2'd2);

   always_comb begin
      slot_in = slot_ff;
      if (accept) begin
         slot_in = (slot_eff == 2'd0) ? 2'd1 : (slot_eff == 2'd1) ? 2'd2 : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && slot_eff == 2'd0) begin
         h0_x_ff <= req_pos_x;
         h0_y_ff <= req_pos_y;
         h0_z_ff <= req_pos_z;
         h0_u_ff <= req_tex_u;
         h0_v_ff <= req_tex_v;
      end
      if (accept && slot_eff == 2'd1) begin
         h1_x_ff <= req_pos_x;
         h1_y_ff <= req_pos_y;
         h1_z_ff <= req_pos_z;
         h1_u_ff <= req_tex_u;
         h1_v_ff <= req_tex_v;
      end
   end

   // edges from vertex 0
   always_comb begin
      face.p_x = DIFF_W'(h1_x_ff) - DIFF_W'(h0_x_ff);
      face.p_y = DIFF_W'(h1_y_ff) - DIFF_W'(h0_y_ff);
      face.p_z = DIFF_W'(h1_z_ff) - DIFF_W'(h0_z_ff);
      face.q_x = DIFF_W'(req_pos_x) - DIFF_W'(h0_x_ff);
      face.q_y = DIFF_W'(req_pos_y) - DIFF_W'(h0_y_ff);
      face.q_z = DIFF_W'(req_pos_z) - DIFF_W'(h0_z_ff);
      face.s1  = DIFF_W'(h1_u_ff) - DIFF_W'(h0_u_ff);
      face.t1  = DIFF_W'(h1_v_ff) - DIFF_W'(h0_v_ff);
      face.s2  = DIFF_W'(req_tex_u) - DIFF_W'(h0_u_ff);
      face.t2  = DIFF_W'(req_tex_v) - DIFF_W'(h0_v_ff);
   end

endmodule

/* rtl/ttf_queue.sv */
module ttf_queue import ttf_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  face_type in_face,
   output logic     out_valid,
   input  logic     out_ready,
   output face_type out_face
);

   face_type entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_face  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= in_face;
   end

endmodule

/* rtl/ttf_back.sv */
module ttf_back import ttf_pkg::*; #(
   parameter int IN_FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [THR_W-1:0] det_threshold,
   input  logic             face_valid,
   output logic             face_ready,
   input  face_type         face,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output frame_type        frame,
   output logic             last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_SQRT  = 3'd4;
   localparam logic [2:0] ST_DIVLD = 3'd5;
   localparam logic [2:0] ST_DIV   = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   localparam logic [4:0] K_T_LAST  = 5'd13;
   localparam logic [4:0] K_B_FIRST = 5'd14;
   localparam logic [4:0] K_B_LAST  = 5'd19;
   localparam logic [4:0] K_SQ      = 5'd20;

   logic [2:0] state_ff;
   logic [4:0] k_ff;
   logic [1:0] vsel_ff, comp_ff, emit_ff;
   logic [4:0] cnt_ff;
   face_type   face_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  vec_ff [10];
   logic [ACC_W-1:0] sc_mag_ff [3];
   logic             sc_neg_ff [3];
   logic             sc_load_ff;
   logic             sgn_ff [9];
   logic [MAG_W-1:0] mag_ff [9];
   logic [SQ_W-1:0]   sq_x_ff;
   logic [REM_W-1:0]  sq_rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [DREM_W-1:0] dv_rem_ff;
   logic [QUO_W-1:0]  dv_bits_ff, quo_ff;
   logic signed [OUT_W-1:0] res_ff [9];

   logic signed [DIFF_W-1:0] op_a, op_b;
   logic signed [DIFF_W-1:0] nc_x, nc_y, nc_z, tc_x, tc_y, tc_z;
   logic [3:0] elem_idx, base_idx;
   logic [4:0] k_sq;
   logic [MAG_W-1:0] mag_sel;
   logic signed [ACC_W-1:0] prod_ext, sq_sum;
   logic [ACC_W-1:0] det_mag, thr_wide, sc_or;
   logic neg_det;
   logic [REM_W-1:0] sq_rem2, sq_trial;
   logic sq_ge;
   logic [NUM_W-1:0] num;
   logic [DREM_W-1:0] dv_rem2;
   logic dv_ge;
   logic [QUO_W-1:0] quo_next;
   logic signed [ACC_W-1:0] ld_val [3];

   function automatic logic signed [DIFF_W-1:0] to_signed(input logic s,
                                                          input logic [MAG_W-1:0] m);
      logic signed [DIFF_W-1:0] v;
      v = DIFF_W'(m);
      return s ? -v : v;
   endfunction

   assign nc_x = to_signed(sgn_ff[0], mag_ff[0]);
   assign nc_y = to_signed(sgn_ff[1], mag_ff[1]);
   assign nc_z = to_signed(sgn_ff[2], mag_ff[2]);
   assign tc_x = to_signed(sgn_ff[3], mag_ff[3]);
   assign tc_y = to_signed(sgn_ff[4], mag_ff[4]);
   assign tc_z = to_signed(sgn_ff[5], mag_ff[5]);

   assign base_idx = {1'b0, vsel_ff, 1'b0} + {2'b00, vsel_ff};
   assign k_sq     = k_ff - K_SQ;
   assign elem_idx = (state_ff == ST_DIVLD || state_ff == ST_DIV)
                     ? base_idx + {2'b00, comp_ff} : k_sq[3:0];
   assign mag_sel  = mag_ff[elem_idx];

   always_comb begin
      unique case (k_ff)
         5'd0:  begin op_a = face_ff.s1;  op_b = face_ff.t2;  end
         5'd1:  begin op_a = face_ff.s2;  op_b = face_ff.t1;  end
         5'd2:  begin op_a = face_ff.p_y; op_b = face_ff.q_z; end
         5'd3:  begin op_a = face_ff.p_z; op_b = face_ff.q_y; end
         5'd4:  begin op_a = face_ff.p_z; op_b = face_ff.q_x; end
         5'd5:  begin op_a = face_ff.p_x; op_b = face_ff.q_z; end
         5'd6:  begin op_a = face_ff.p_x; op_b = face_ff.q_y; end
         5'd7:  begin op_a = face_ff.p_y; op_b = face_ff.q_x; end
         5'd8:  begin op_a = face_ff.t2;  op_b = face_ff.p_x; end
         5'd9:  begin op_a = face_ff.t1;  op_b = face_ff.q_x; end
         5'd10: begin op_a = face_ff.t2;  op_b = face_ff.p_y; end
         5'd11: begin op_a = face_ff.t1;  op_b = face_ff.q_y; end
         5'd12: begin op_a = face_ff.t2;  op_b = face_ff.p_z; end
         5'd13: begin op_a = face_ff.t1;  op_b = face_ff.q_z; end
         5'd14: begin op_a = tc_y; op_b = nc_z; end
         5'd15: begin op_a = tc_z; op_b = nc_y; end
         5'd16: begin op_a = tc_z; op_b = nc_x; end
         5'd17: begin op_a = tc_x; op_b = nc_z; end
         5'd18: begin op_a = tc_x; op_b = nc_y; end
         5'd19: begin op_a = tc_y; op_b = nc_x; end
         5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28: begin
            op_a = DIFF_W'(mag_sel);
            op_b = DIFF_W'(mag_sel);
         end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_ext = ACC_W'(prod_ff);
   assign sq_sum   = ((k_ff == 5'd20 || k_ff == 5'd23 || k_ff == 5'd26) ? '0 : acc_ff)
                     + prod_ext;

   // degenerate determinant keeps scale one
   assign det_mag  = vec_ff[0][ACC_W-1] ? ACC_W'(-vec_ff[0]) : ACC_W'(vec_ff[0]);
   assign thr_wide = ACC_W'(det_threshold) << IN_FRAC_BITS;
   assign neg_det  = vec_ff[0][ACC_W-1] && !(det_mag <= thr_wide);

   always_comb begin
      unique case (vsel_ff)
         2'd0:    begin ld_val[0] = vec_ff[1]; ld_val[1] = vec_ff[2]; ld_val[2] = vec_ff[3]; end
         2'd1:    begin ld_val[0] = vec_ff[4]; ld_val[1] = vec_ff[5]; ld_val[2] = vec_ff[6]; end
         default: begin ld_val[0] = vec_ff[7]; ld_val[1] = vec_ff[8]; ld_val[2] = vec_ff[9]; end
      endcase
   end

   assign sc_or = sc_mag_ff[0] | sc_mag_ff[1] | sc_mag_ff[2];

   assign sq_rem2  = {sq_rem_ff[REM_W-3:0], sq_x_ff[SQ_W-1:SQ_W-2]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = (sq_rem2 >= sq_trial);

   assign num      = {mag_sel, {ONE_SHIFT{1'b0}}} + NUM_W'(root_ff[ROOT_W-1:1]);
   assign dv_rem2  = {dv_rem_ff[DREM_W-2:0], dv_bits_ff[QUO_W-1]};
   assign dv_ge    = (root_ff != '0) && (dv_rem2 >= DREM_W'(root_ff));
   assign quo_next = {quo_ff[QUO_W-2:0], dv_ge};

   assign face_ready = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_EMIT);
   assign last       = (emit_ff == 2'd2);

   always_comb begin
      frame.normal_x    = res_ff[0];
      frame.normal_y    = res_ff[1];
      frame.normal_z    = res_ff[2];
      frame.tangent_x   = res_ff[3];
      frame.tangent_y   = res_ff[4];
      frame.tangent_z   = res_ff[5];
      frame.bitangent_x = res_ff[6];
      frame.bitangent_y = res_ff[7];
      frame.bitangent_z = res_ff[8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         emit_ff  <= 2'd0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (face_valid) begin
                  face_ff <= face;
                  k_ff    <= 5'd0;
                  vsel_ff <= 2'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff  <= op_a * op_b;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               k_ff <= k_ff + 5'd1;
               if (k_ff < K_SQ) begin
                  if (!k_ff[0]) acc_ff <= prod_ext;
                  else vec_ff[k_ff[4:1]] <= acc_ff - prod_ext;
                  if (k_ff == K_T_LAST || k_ff == K_B_LAST) begin
                     vsel_ff    <= (k_ff == K_B_LAST) ? 2'd2 : 2'd0;
                     sc_load_ff <= 1'b1;
                     state_ff   <= ST_SCALE;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end else begin
                  acc_ff <= sq_sum;
                  if (k_ff == 5'd22 || k_ff == 5'd25 || k_ff == 5'd28) begin
                     sq_x_ff   <= sq_sum[SQ_W-1:0];
                     sq_rem_ff <= '0;
                     root_ff   <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= ST_SQRT;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_SCALE: begin
               if (sc_load_ff) begin
                  sc_load_ff <= 1'b0;
                  for (int i = 0; i < 3; i++) begin
                     sc_mag_ff[i] <= ld_val[i][ACC_W-1] ? ACC_W'(-ld_val[i])
                                                        : ACC_W'(ld_val[i]);
                     sc_neg_ff[i] <= ld_val[i][ACC_W-1] ^
                                     ((vsel_ff == 2'd1) && neg_det && (ld_val[i] != '0));
                  end
               end else if (sc_or[ACC_W-1:MAG_W] != '0) begin
                  for (int i = 0; i < 3; i++) sc_mag_ff[i] <= sc_mag_ff[i] >> 1;
               end else if (sc_or != '0 && !sc_or[MAG_W-1]) begin
                  for (int i = 0; i < 3; i++) sc_mag_ff[i] <= sc_mag_ff[i] << 1;
               end else begin
                  for (int i = 0; i < 3; i++) begin
                     sgn_ff[base_idx + 4'(i)] <= sc_neg_ff[i];
                     mag_ff[base_idx + 4'(i)] <= sc_mag_ff[i][MAG_W-1:0];
                  end
                  if (vsel_ff == 2'd0) begin
                     vsel_ff    <= 2'd1;
                     sc_load_ff <= 1'b1;
                  end else if (vsel_ff == 2'd1) begin
                     k_ff     <= K_B_FIRST;
                     state_ff <= ST_MUL;
                  end else begin
                     k_ff     <= K_SQ;
                     vsel_ff  <= 2'd0;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_SQRT: begin
               sq_rem_ff <= sq_ge ? sq_rem2 - sq_trial : sq_rem2;
               root_ff   <= {root_ff[ROOT_W-2:0], sq_ge};
               sq_x_ff   <= sq_x_ff << 2;
               cnt_ff    <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(ROOT_W - 1)) begin
                  comp_ff  <= 2'd0;
                  state_ff <= ST_DIVLD;
               end
            end
            ST_DIVLD: begin
               dv_rem_ff  <= DREM_W'(num[NUM_W-1:QUO_W]);
               dv_bits_ff <= num[QUO_W-1:0];
               quo_ff     <= '0;
               cnt_ff     <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               dv_rem_ff  <= dv_ge ? dv_rem2 - DREM_W'(root_ff) : dv_rem2;
               dv_bits_ff <= dv_bits_ff << 1;
               quo_ff     <= quo_next;
               cnt_ff     <= cnt_ff + 5'd1;
               if (cnt_ff == 5'(QUO_W - 1)) begin
                  res_ff[elem_idx] <= sgn_ff[elem_idx] ? -OUT_W'(quo_next)
                                                       : OUT_W'(quo_next);
                  if (comp_ff != 2'd2) begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= ST_DIVLD;
                  end else if (vsel_ff == 2'd2) begin
                     emit_ff  <= 2'd0;
                     state_ff <= ST_EMIT;
                  end else begin
                     vsel_ff  <= vsel_ff + 2'd1;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_ready) begin
                  if (emit_ff == 2'd2) begin
                     emit_ff  <= 2'd0;
                     state_ff <= ST_IDLE;
                  end else begin
                     emit_ff <= emit_ff + 2'd1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* rtl/triangle_tangent_frame.sv */
// Per-face tangent frame of a triangle vertex stream. Send one vertex per
// word (position and texture coordinate, signed with IN_FRAC_BITS fraction
// bits); every third vertex closes a face and start_mesh restarts the
// grouping, dropping held vertices, so a trailing incomplete face gives no
// words. For each face the block returns three identical words holding the
// unit normal (P x Q), tangent (t2*P - t1*Q, sign-corrected by the UV
// determinant unless its magnitude is at or below det_threshold) and
// left-handed bitangent (T x N), all Q2.14, with last_of_face set on the
// third; a zero vector stays zero. The input side assembles faces at one
// vertex per cycle while the two-face queue has room, so it keeps accepting
// while the compute engine works until that queue is full. The engine runs
// one face at a time through a single shared 33x33 multiplier, a
// one-bit-per-cycle block-scaling shifter, a two-bits-per-step square root
// and a bit-serial divider, working through the products and squares, the
// shifting, square root and division for each vector and then the three
// output words. det_threshold sits at byte address 0 (reset 7); write it
// only while the block is idle.
module triangle_tangent_frame import ttf_pkg::*; #(
   parameter int IN_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic signed [COORD_W-1:0] req_pos_z,
   input  logic signed [COORD_W-1:0] req_tex_u,
   input  logic signed [COORD_W-1:0] req_tex_v,
   input  logic                      req_start_mesh,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [OUT_W-1:0]   rsp_normal_x,
   output logic signed [OUT_W-1:0]   rsp_normal_y,
   output logic signed [OUT_W-1:0]   rsp_normal_z,
   output logic signed [OUT_W-1:0]   rsp_tangent_x,
   output logic signed [OUT_W-1:0]   rsp_tangent_y,
   output logic signed [OUT_W-1:0]   rsp_tangent_z,
   output logic signed [OUT_W-1:0]   rsp_bitangent_x,
   output logic signed [OUT_W-1:0]   rsp_bitangent_y,
   output logic signed [OUT_W-1:0]   rsp_bitangent_z,
   output logic                      rsp_last_of_face,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   localparam logic [2:0] ADDR_DET_THRESHOLD = 3'd0;

   logic [THR_W-1:0] det_threshold_ff;
   face_type  front_face, queue_face;
   logic      front_valid, front_ready, queue_valid, queue_ready;
   frame_type frame;

   // configuration: single register, no wait states
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_DET_THRESHOLD) ? 32'(det_threshold_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_threshold_ff <= DET_THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr == ADDR_DET_THRESHOLD) begin
         det_threshold_ff <= csr_pwdata[THR_W-1:0];
      end
   end

   // group vertices into faces
   ttf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_tex_u      (req_tex_u),
      .req_tex_v      (req_tex_v),
      .req_start_mesh (req_start_mesh),
      .face_valid     (front_valid),
      .face_ready     (front_ready),
      .face           (front_face)
   );

   // hold finished faces while the engine is busy
   ttf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_face   (front_face),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_face  (queue_face)
   );

   // compute and emit the frame three times
   ttf_back #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .det_threshold (det_threshold_ff),
      .face_valid    (queue_valid),
      .face_ready    (queue_ready),
      .face          (queue_face),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .frame         (frame),
      .last          (rsp_last_of_face)
   );

   assign rsp_normal_x    = frame.normal_x;
   assign rsp_normal_y    = frame.normal_y;
   assign rsp_normal_z    = frame.normal_z;
   assign rsp_tangent_x   = frame.tangent_x;
   assign rsp_tangent_y   = frame.tangent_y;
   assign rsp_tangent_z   = frame.tangent_z;
   assign rsp_bitangent_x = frame.bitangent_x;
   assign rsp_bitangent_y = frame.bitangent_y;
   assign rsp_bitangent_z = frame.bitangent_z;

endmodule
